>>> src/cpec_pkg.sv
// Package for the circle pair collision pipeline: widths, payload structs and helpers.
// No dependencies.
`timescale 1ns / 1ps
package cpec_pkg;

  localparam int FracBits = 12;
  localparam int PosW = 16;
  localparam int MassW = 16;
  localparam int RadW = 13;

  typedef struct packed {
    logic signed [PosW-1:0] a_pos_x;
    logic signed [PosW-1:0] a_pos_y;
    logic signed [PosW-1:0] a_vel_x;
    logic signed [PosW-1:0] a_vel_y;
    logic [MassW-1:0]       a_mass;
    logic [RadW-1:0]        a_radius;
    logic signed [PosW-1:0] b_pos_x;
    logic signed [PosW-1:0] b_pos_y;
    logic signed [PosW-1:0] b_vel_x;
    logic signed [PosW-1:0] b_vel_y;
    logic [MassW-1:0]       b_mass;
    logic [RadW-1:0]        b_radius;
  } pair_t;

  typedef struct packed {
    logic                   hit;
    logic signed [PosW-1:0] new_a_pos_x;
    logic signed [PosW-1:0] new_a_pos_y;
    logic signed [PosW-1:0] new_a_vel_x;
    logic signed [PosW-1:0] new_a_vel_y;
    logic signed [PosW-1:0] new_b_pos_x;
    logic signed [PosW-1:0] new_b_pos_y;
    logic signed [PosW-1:0] new_b_vel_x;
    logic signed [PosW-1:0] new_b_vel_y;
  } result_t;

  // Saturate a wide signed value to 16 bits
  function automatic logic signed [PosW-1:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return v[PosW-1:0];
  endfunction

endpackage

>>> src/cpec_if.sv
// Valid/ready channel interface carrying one request payload.
// No dependencies; the payload type is a parameter.
`timescale 1ns / 1ps
interface cpec_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/cpec_engine.sv
// Collision arithmetic as a stall-able pipeline; one request per cycle while en_i is high.
// Depends on cpec_pkg. Deep pipeline with isqrt and divider stages unrolled into registers.
`timescale 1ns / 1ps
module cpec_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_vld_i,
  input  cpec_pkg::pair_t  in_i,
  output logic             out_vld_o,
  output cpec_pkg::result_t out_o
);
  import cpec_pkg::*;

  // Register stages: front 3, sqrt 16, normal divide 30, normal 1, projections 1,
  // dot products 1, mass products 1, mass divide 45, final products 1, add 1: 100 in all.
  // Each stage below is kept simple; a generic valid shift follows the data.
  localparam int SqN = 16;
  localparam int NdN = 30;
  localparam int MdN = 44;

  // Common per-item carry
  typedef struct packed {
    pair_t                   p;
    logic                    hit;
    logic                    zero;
    logic signed [16:0]      dx;
    logic signed [16:0]      dy;
    logic [33:0]             d2;
    logic [13:0]             rs;
  } base_t;

  // ---------------- stage 1: differences
  base_t s1_q;
  logic v1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= in_vld_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q.p    <= in_i;
      s1_q.hit  <= 1'b0;
      s1_q.zero <= 1'b0;
      s1_q.d2   <= '0;
      s1_q.dx   <= 17'(in_i.a_pos_x) - 17'(in_i.b_pos_x);
      s1_q.dy   <= 17'(in_i.a_pos_y) - 17'(in_i.b_pos_y);
      s1_q.rs   <= 14'(in_i.a_radius) + 14'(in_i.b_radius);
    end
  end

  // ---------------- stage 2: squares
  base_t s2_q;
  logic v2_q;
  logic [33:0] dxx_q, dyy_q;
  logic [27:0] rss_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en_i) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q  <= s1_q;
      dxx_q <= 34'(s1_q.dx * s1_q.dx);
      dyy_q <= 34'(s1_q.dy * s1_q.dy);
      rss_q <= 28'(s1_q.rs) * 28'(s1_q.rs);
    end
  end

  // ---------------- stage 3: compare
  base_t s3_q;
  logic v3_q;
  logic [33:0] d2_w;
  assign d2_w = dxx_q + dyy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en_i) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q.p    <= s2_q.p;
      s3_q.dx   <= s2_q.dx;
      s3_q.dy   <= s2_q.dy;
      s3_q.rs   <= s2_q.rs;
      s3_q.d2   <= d2_w;
      s3_q.hit  <= d2_w < 34'(rss_q);
      s3_q.zero <= d2_w == '0;
    end
  end

  // ---------------- sqrt: one result bit per stage (digit recurrence)
  // partial root is kept scaled by the current bit, so it needs the full width
  base_t        sq_b_q [SqN+1];
  logic         sq_v_q [SqN+1];
  logic [33:0]  sq_r_q [SqN+1];
  logic [33:0]  sq_s_q [SqN+1];
  always_comb begin
    sq_b_q[0] = s3_q;
    sq_v_q[0] = v3_q;
    sq_r_q[0] = s3_q.d2;
    sq_s_q[0] = '0;
  end
  for (genvar k = 0; k < SqN + 1; k++) begin : g_sq
    if (k < SqN) begin : g_st
      logic [33:0] bit_w, trial_w;
      assign bit_w   = 34'(1) << (2 * (SqN - k));
      assign trial_w = sq_s_q[k] + bit_w;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) sq_v_q[k+1] <= 1'b0;
        else if (en_i) sq_v_q[k+1] <= sq_v_q[k];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sq_b_q[k+1] <= sq_b_q[k];
          if (sq_r_q[k] >= trial_w) begin
            sq_r_q[k+1] <= sq_r_q[k] - trial_w;
            sq_s_q[k+1] <= (sq_s_q[k] >> 1) + bit_w;
          end else begin
            sq_r_q[k+1] <= sq_r_q[k];
            sq_s_q[k+1] <= sq_s_q[k] >> 1;
          end
        end
      end
    end
  end
  // last bit combinationally (bit = 1)
  logic [16:0] root_w;
  always_comb begin
    if (sq_r_q[SqN] >= sq_s_q[SqN] + 34'd1) root_w = 17'((sq_s_q[SqN] >> 1) + 34'd1);
    else root_w = 17'(sq_s_q[SqN] >> 1);
  end

  // ---------------- stage D: dist and magnitudes for normal divide
  base_t       nd_b_q [NdN];
  logic        nd_v_q [NdN];
  logic [16:0] nd_dist_q [NdN];
  logic [29:0] nd_rx_q [NdN], nd_ry_q [NdN];
  logic [29:0] nd_qx_q [NdN], nd_qy_q [NdN];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) nd_v_q[0] <= 1'b0;
    else if (en_i) nd_v_q[0] <= sq_v_q[SqN];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nd_b_q[0]    <= sq_b_q[SqN];
      nd_dist_q[0] <= sq_b_q[SqN].zero ? 17'(1 << FracBits) : root_w;
      nd_rx_q[0]   <= '0;
      nd_ry_q[0]   <= '0;
      nd_qx_q[0]   <= 30'(sq_b_q[SqN].dx[16] ? -sq_b_q[SqN].dx : sq_b_q[SqN].dx) << FracBits;
      nd_qy_q[0]   <= 30'(sq_b_q[SqN].dy[16] ? -sq_b_q[SqN].dy : sq_b_q[SqN].dy) << FracBits;
    end
  end
  // restoring divide, one quotient bit per stage (two lanes); 29 here, the 30th below
  for (genvar k = 0; k < NdN - 1; k++) begin : g_nd
    logic [30:0] tx_w, ty_w;
    assign tx_w = {nd_rx_q[k], nd_qx_q[k][29]} - {13'd0, 1'b0, nd_dist_q[k]};
    assign ty_w = {nd_ry_q[k], nd_qy_q[k][29]} - {13'd0, 1'b0, nd_dist_q[k]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) nd_v_q[k+1] <= 1'b0;
      else if (en_i) nd_v_q[k+1] <= nd_v_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nd_b_q[k+1]    <= nd_b_q[k];
        nd_dist_q[k+1] <= nd_dist_q[k];
        nd_rx_q[k+1] <= tx_w[30] ? {nd_rx_q[k][28:0], nd_qx_q[k][29]} : tx_w[29:0];
        nd_qx_q[k+1] <= {nd_qx_q[k][28:0], ~tx_w[30]};
        nd_ry_q[k+1] <= ty_w[30] ? {nd_ry_q[k][28:0], nd_qy_q[k][29]} : ty_w[29:0];
        nd_qy_q[k+1] <= {nd_qy_q[k][28:0], ~ty_w[30]};
      end
    end
  end
  // final quotient bit; the sign is applied in stage N
  logic [30:0] fx_w, fy_w;
  logic [29:0] qx_w, qy_w;
  assign fx_w = {nd_rx_q[NdN-1], nd_qx_q[NdN-1][29]} - {14'd0, nd_dist_q[NdN-1]};
  assign fy_w = {nd_ry_q[NdN-1], nd_qy_q[NdN-1][29]} - {14'd0, nd_dist_q[NdN-1]};
  assign qx_w = {nd_qx_q[NdN-1][28:0], ~fx_w[30]};
  assign qy_w = {nd_qy_q[NdN-1][28:0], ~fy_w[30]};

  // ---------------- stage N: normal
  typedef struct packed {
    base_t               b;
    logic signed [17:0]  nx;
    logic signed [17:0]  ny;
    logic [16:0]         dlen;
  } nrm_t;
  nrm_t n_q;
  logic vn_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vn_q <= 1'b0;
    else if (en_i) vn_q <= nd_v_q[NdN-1];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q.b    <= nd_b_q[NdN-1];
      n_q.dlen <= nd_dist_q[NdN-1];
      if (nd_b_q[NdN-1].zero) begin
        n_q.nx <= 18'sd1 <<< FracBits;
        n_q.ny <= '0;
      end else begin
        n_q.nx <= nd_b_q[NdN-1].dx[16] ? -18'(qx_w) : 18'(qx_w);
        n_q.ny <= nd_b_q[NdN-1].dy[16] ? -18'(qy_w) : 18'(qy_w);
      end
    end
  end

  // ---------------- stage P: projections (products)
  typedef struct packed {
    nrm_t                n;
    logic signed [34:0]  pax, pay, pbx, pby;
    logic signed [17:0]  ma, mb;
    logic signed [15:0]  ov;
  } prj_t;
  prj_t p_q;
  logic vp_q;
  logic both0_w;
  assign both0_w = (n_q.b.p.a_mass == '0) && (n_q.b.p.b_mass == '0);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vp_q <= 1'b0;
    else if (en_i) vp_q <= vn_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q.n   <= n_q;
      p_q.pax <= 35'(n_q.b.p.a_vel_x * n_q.nx);
      p_q.pay <= 35'(n_q.b.p.a_vel_y * n_q.ny);
      p_q.pbx <= 35'(n_q.b.p.b_vel_x * n_q.nx);
      p_q.pby <= 35'(n_q.b.p.b_vel_y * n_q.ny);
      p_q.ma  <= both0_w ? 18'sd1 : 18'($signed({2'b0, n_q.b.p.a_mass}));
      p_q.mb  <= both0_w ? 18'sd1 : 18'($signed({2'b0, n_q.b.p.b_mass}));
      p_q.ov  <= 16'($signed({2'b0, n_q.b.rs}) - $signed({1'b0, n_q.dlen}));
    end
  end

  // ---------------- stage C: aci/bci
  typedef struct packed {
    nrm_t                n;
    logic signed [23:0]  aci, bci;
    logic signed [17:0]  ma, mb;
    logic signed [15:0]  ov;
  } ci_t;
  ci_t c_q;
  logic vc_q;
  logic signed [35:0] sa_w, sb_w;
  assign sa_w = 36'(p_q.pax) + 36'(p_q.pay);
  assign sb_w = 36'(p_q.pbx) + 36'(p_q.pby);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (en_i) vc_q <= vp_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q.n   <= p_q.n;
      c_q.aci <= 24'(sa_w >>> FracBits);
      c_q.bci <= 24'(sb_w >>> FracBits);
      c_q.ma  <= p_q.ma;
      c_q.mb  <= p_q.mb;
      c_q.ov  <= p_q.ov;
    end
  end

  // ---------------- stage M: mass products
  typedef struct packed {
    nrm_t                n;
    logic signed [23:0]  aci, bci;
    logic signed [42:0]  t1, t2, t3, t4;
    logic signed [33:0]  o1n, o2n;
    logic [17:0]         ms;
  } mp_t;
  mp_t m_q;
  logic vm_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vm_q <= 1'b0;
    else if (en_i) vm_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q.n   <= c_q.n;
      m_q.aci <= c_q.aci;
      m_q.bci <= c_q.bci;
      m_q.t1  <= 43'(c_q.aci * (c_q.ma - c_q.mb));
      m_q.t2  <= 43'(c_q.bci * (c_q.mb <<< 1));
      m_q.t3  <= 43'(c_q.bci * (c_q.mb - c_q.ma));
      m_q.t4  <= 43'(c_q.aci * (c_q.ma <<< 1));
      m_q.o1n <= 34'(c_q.ov * c_q.mb);
      m_q.o2n <= 34'(c_q.ov * c_q.ma);
      m_q.ms  <= 18'(c_q.ma + c_q.mb);
    end
  end

  // ---------------- mass divide: four lanes, magnitude restoring, one bit per stage
  localparam int DW = 44;
  typedef struct packed {
    nrm_t                n;
    logic signed [23:0]  aci, bci;
    logic [3:0]          neg;
    logic [17:0]         ms;
  } md_t;
  md_t         md_b_q [MdN+1];
  logic        md_v_q [MdN+1];
  logic [DW-1:0] md_q_q [MdN+1][4];
  logic [18:0]   md_r_q [MdN+1][4];
  logic signed [43:0] num_w [4];
  assign num_w[0] = 44'(m_q.t1) + 44'(m_q.t2);
  assign num_w[1] = 44'(m_q.t3) + 44'(m_q.t4);
  assign num_w[2] = 44'(m_q.o1n);
  assign num_w[3] = 44'(m_q.o2n);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) md_v_q[0] <= 1'b0;
    else if (en_i) md_v_q[0] <= vm_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      md_b_q[0].n   <= m_q.n;
      md_b_q[0].aci <= m_q.aci;
      md_b_q[0].bci <= m_q.bci;
      md_b_q[0].ms  <= m_q.ms;
      for (int l = 0; l < 4; l++) begin
        md_b_q[0].neg[l] <= num_w[l][43];
        md_q_q[0][l] <= num_w[l][43] ? 44'(-num_w[l]) : 44'(num_w[l]);
        md_r_q[0][l] <= '0;
      end
    end
  end
  // one stage per dividend bit, so the whole magnitude is consumed
  for (genvar k = 0; k < MdN; k++) begin : g_md
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) md_v_q[k+1] <= 1'b0;
      else if (en_i) md_v_q[k+1] <= md_v_q[k];
    end
    always_ff @(posedge clk_i) begin
      logic [19:0] t;
      if (en_i) begin
        md_b_q[k+1] <= md_b_q[k];
        for (int l = 0; l < 4; l++) begin
          t = {md_r_q[k][l], md_q_q[k][l][DW-1]} - {2'b0, md_b_q[k].ms};
          md_r_q[k+1][l] <= t[19] ? {md_r_q[k][l][17:0], md_q_q[k][l][DW-1]} : t[18:0];
          md_q_q[k+1][l] <= {md_q_q[k][l][DW-2:0], ~t[19]};
        end
      end
    end
  end

  // ---------------- stage F: final products
  typedef struct packed {
    base_t               b;
    logic signed [35:0]  ax, ay, bx, by, pax, pay, pbx, pby;
  } fp_t;
  fp_t f_q;
  logic vf_q;
  logic signed [44:0] qs_w [4];
  logic signed [25:0] da_w, db_w;
  logic signed [17:0] o1_w, o2_w;
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      qs_w[l] = md_b_q[MdN].neg[l] ? -$signed({1'b0, md_q_q[MdN][l]})
                                   : $signed({1'b0, md_q_q[MdN][l]});
    end
    da_w = 26'(qs_w[0]) - 26'(md_b_q[MdN].aci);
    db_w = 26'(qs_w[1]) - 26'(md_b_q[MdN].bci);
    o1_w = 18'(qs_w[2]);
    o2_w = 18'(qs_w[3]);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vf_q <= 1'b0;
    else if (en_i) vf_q <= md_v_q[MdN];
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q.b   <= md_b_q[MdN].n.b;
      f_q.ax  <= 36'(md_b_q[MdN].n.nx * da_w);
      f_q.ay  <= 36'(md_b_q[MdN].n.ny * da_w);
      f_q.bx  <= 36'(md_b_q[MdN].n.nx * db_w);
      f_q.by  <= 36'(md_b_q[MdN].n.ny * db_w);
      f_q.pax <= 36'(md_b_q[MdN].n.nx * o1_w);
      f_q.pay <= 36'(md_b_q[MdN].n.ny * o1_w);
      f_q.pbx <= 36'(md_b_q[MdN].n.nx * o2_w);
      f_q.pby <= 36'(md_b_q[MdN].n.ny * o2_w);
    end
  end

  // ---------------- stage O: add and saturate
  result_t o_q;
  logic vo_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (en_i) vo_q <= vf_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_q.hit <= f_q.b.hit;
      if (f_q.b.hit) begin
        o_q.new_a_pos_x <= sat16(48'(f_q.b.p.a_pos_x) + 48'(f_q.pax >>> FracBits));
        o_q.new_a_pos_y <= sat16(48'(f_q.b.p.a_pos_y) + 48'(f_q.pay >>> FracBits));
        o_q.new_a_vel_x <= sat16(48'(f_q.b.p.a_vel_x) + 48'(f_q.ax >>> FracBits));
        o_q.new_a_vel_y <= sat16(48'(f_q.b.p.a_vel_y) + 48'(f_q.ay >>> FracBits));
        o_q.new_b_pos_x <= sat16(48'(f_q.b.p.b_pos_x) - 48'(f_q.pbx >>> FracBits));
        o_q.new_b_pos_y <= sat16(48'(f_q.b.p.b_pos_y) - 48'(f_q.pby >>> FracBits));
        o_q.new_b_vel_x <= sat16(48'(f_q.b.p.b_vel_x) + 48'(f_q.bx >>> FracBits));
        o_q.new_b_vel_y <= sat16(48'(f_q.b.p.b_vel_y) + 48'(f_q.by >>> FracBits));
      end else begin
        o_q.new_a_pos_x <= f_q.b.p.a_pos_x;
        o_q.new_a_pos_y <= f_q.b.p.a_pos_y;
        o_q.new_a_vel_x <= f_q.b.p.a_vel_x;
        o_q.new_a_vel_y <= f_q.b.p.a_vel_y;
        o_q.new_b_pos_x <= f_q.b.p.b_pos_x;
        o_q.new_b_pos_y <= f_q.b.p.b_pos_y;
        o_q.new_b_vel_x <= f_q.b.p.b_vel_x;
        o_q.new_b_vel_y <= f_q.b.p.b_vel_y;
      end
    end
  end

  assign out_vld_o = vo_q;
  assign out_o     = o_q;

endmodule

>>> src/circle_pair_elastic_collision.sv
// Top level of the circle pair collision block: handshake and output skid stage.
// Depends on cpec_pkg, cpec_if and cpec_engine.
//
//   channel  | dir | payload
//   pair_in  | in  | cpec_pkg::pair_t   (two particles)
//   res_out  | out | cpec_pkg::result_t (hit and updated particles)
//
// One request per cycle sustained while the output is not stalled; an accepted
// request passes the engine and then the output register (100 engine stages: squares,
// one stage per root bit, one per quotient bit of each divider; plus output).
// Reset clears every valid bit; payload registers are not reset.
// A stalled output fills the skid stage, which then freezes the whole pipeline; the skid
// keeps input ready registered so no request is lost or repeated.
`timescale 1ns / 1ps
module circle_pair_elastic_collision (
  input  logic clk_i,
  input  logic rst_ni,
  cpec_if.sink   pair_in,
  cpec_if.source res_out
);
  import cpec_pkg::*;

  logic    en_w, eng_vld_w;
  result_t eng_res_w;
  logic    sk_v_q;
  result_t sk_q;
  logic    ov_q;
  result_t ob_q;

  // pipeline advances when the output buffer can absorb its head
  assign en_w = !sk_v_q;
  assign pair_in.ready = en_w;

  cpec_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en_w),
    .in_vld_i  (pair_in.valid),
    .in_i      (pair_in.data),
    .out_vld_o (eng_vld_w),
    .out_o     (eng_res_w)
  );

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      if (!ov_q || res_out.ready) begin
        if (sk_v_q) begin
          ov_q   <= 1'b1;
          sk_v_q <= 1'b0;
        end else begin
          ov_q <= en_w && eng_vld_w;
        end
      end else if (en_w && eng_vld_w) begin
        sk_v_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (!ov_q || res_out.ready) begin
      ob_q <= sk_v_q ? sk_q : eng_res_w;
    end else if (en_w && eng_vld_w) begin
      sk_q <= eng_res_w;
    end
  end

  assign res_out.valid = ov_q;
  assign res_out.data  = ob_q;

  // skid holds a request only while the output register holds one too
  assert property (@(posedge clk_i) disable iff (!rst_ni) sk_v_q |-> ov_q)
    else $error("skid full while output empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !res_out.ready) |=> ov_q)
    else $error("output request dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sk_v_q && !res_out.ready) |=> sk_v_q)
    else $error("skid request dropped");

endmodule

>>> verif/testbench.sv
// Testbench for circle_pair_elastic_collision: directed table then random pairs,
// checked against a local collision predictor. Depends on cpec_pkg and cpec_if.
`timescale 1ns / 1ps
module testbench;
  import cpec_pkg::*;

  localparam int Latency = 200;
  localparam int WatchLimit = 5000;
  localparam int NumRandom = 1800;
  localparam int PairW = $bits(pair_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cpec_if #(.T(pair_t)) pair_if ();
  cpec_if #(.T(result_t)) res_if ();

  circle_pair_elastic_collision uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .pair_in(pair_if.sink),
    .res_out(res_if.source)
  );

  always #5 clk_i = ~clk_i;

  result_t expected_q[$];
  int errors = 0;
  int watch = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  // Directed rows: pair plus optional typed-in result
  typedef struct {
    pair_t   p;
    bit      has_res;
    result_t r;
  } row_t;
  row_t rows[$];

  function automatic longint fshift(longint x);
    if (x >= 0) return x / 4096;
    return -((-x + 4095) / 4096);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint root_floor(longint x);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Predicted outcome of one collision
  function automatic result_t collide(pair_t p);
    result_t r;
    longint apx, apy, avx, avy, ma, ra, bpx, bpy, bvx, bvy, mb, rb;
    longint dx, dy, d2, rs, dlen, nx, ny, aci, bci, acf, bcf, msum, ov, o1, o2;
    apx = p.a_pos_x; apy = p.a_pos_y; avx = p.a_vel_x; avy = p.a_vel_y;
    bpx = p.b_pos_x; bpy = p.b_pos_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
    ma = longint'(p.a_mass); ra = longint'(p.a_radius);
    mb = longint'(p.b_mass); rb = longint'(p.b_radius);
    dx = apx - bpx; dy = apy - bpy;
    d2 = dx * dx + dy * dy;
    rs = ra + rb;
    r.hit = 1'b0;
    r.new_a_pos_x = p.a_pos_x; r.new_a_pos_y = p.a_pos_y;
    r.new_a_vel_x = p.a_vel_x; r.new_a_vel_y = p.a_vel_y;
    r.new_b_pos_x = p.b_pos_x; r.new_b_pos_y = p.b_pos_y;
    r.new_b_vel_x = p.b_vel_x; r.new_b_vel_y = p.b_vel_y;
    if (!(d2 < rs * rs)) return r;
    if (d2 == 0) begin
      nx = 4096; ny = 0; dlen = 4096;
    end else begin
      dlen = root_floor(d2);
      nx = (dx * 4096) / dlen;
      ny = (dy * 4096) / dlen;
    end
    if (ma + mb == 0) begin
      ma = 1; mb = 1;
    end
    msum = ma + mb;
    aci = fshift(avx * nx + avy * ny);
    bci = fshift(bvx * nx + bvy * ny);
    acf = (aci * (ma - mb) + 2 * mb * bci) / msum;
    bcf = (bci * (mb - ma) + 2 * ma * aci) / msum;
    ov = rs - dlen;
    o1 = (ov * mb) / msum;
    o2 = (ov * ma) / msum;
    r.hit = 1'b1;
    r.new_a_pos_x = clip16(apx + fshift(nx * o1));
    r.new_a_pos_y = clip16(apy + fshift(ny * o1));
    r.new_a_vel_x = clip16(avx + fshift(nx * (acf - aci)));
    r.new_a_vel_y = clip16(avy + fshift(ny * (acf - aci)));
    r.new_b_pos_x = clip16(bpx - fshift(nx * o2));
    r.new_b_pos_y = clip16(bpy - fshift(ny * o2));
    r.new_b_vel_x = clip16(bvx + fshift(nx * (bcf - bci)));
    r.new_b_vel_y = clip16(bvy + fshift(ny * (bcf - bci)));
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Random pair: mostly near or overlapping, some noise and extremes
  function automatic pair_t rand_pair();
    pair_t p;
    int sel;
    p = pair_t'(PairW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      p.a_radius = 13'($urandom_range(0, 4096));
      p.b_radius = 13'($urandom_range(0, 4096));
      p.b_pos_x = p.a_pos_x + $signed(16'($urandom_range(0, 8192) - 4096));
      p.b_pos_y = p.a_pos_y + $signed(16'($urandom_range(0, 8192) - 4096));
      if ($urandom_range(0, 15) == 0) begin
        p.b_pos_x = p.a_pos_x; p.b_pos_y = p.a_pos_y;
      end
    end else if (sel < 8) begin
      p.a_radius = 13'($urandom); p.b_radius = 13'($urandom);
    end
    if ($urandom_range(0, 19) == 0) p.a_mass = '0;
    if ($urandom_range(0, 19) == 0) p.b_mass = '0;
    return p;
  endfunction

  function automatic row_t mk(pair_t p, bit has_res);
    row_t w;
    w.p = p;
    w.has_res = has_res;
    w.r = has_res ? collide(p) : '0;
    return w;
  endfunction

  // Build the directed table
  task automatic build_table();
    pair_t p;
    result_t r;
    row_t w;
    // far apart, zero radius: pass through, typed in
    p = '0;
    p.a_pos_x = 16'sh7fff; p.a_pos_y = 16'sh8000; p.a_vel_x = 16'sh8000;
    p.a_vel_y = 16'sh7fff; p.a_mass = 16'hffff;
    p.b_pos_x = 16'sh8000; p.b_pos_y = 16'sh7fff; p.b_vel_x = 16'sh7fff;
    p.b_vel_y = 16'sh8000; p.b_mass = 16'h0001;
    r = '0;
    r.new_a_pos_x = 16'sh7fff; r.new_a_pos_y = 16'sh8000; r.new_a_vel_x = 16'sh8000;
    r.new_a_vel_y = 16'sh7fff; r.new_b_pos_x = 16'sh8000; r.new_b_pos_y = 16'sh7fff;
    r.new_b_vel_x = 16'sh7fff; r.new_b_vel_y = 16'sh8000;
    w.p = p; w.has_res = 1'b1; w.r = r;
    rows.push_back(w);
    // coinciding centres, zero radii: not an overlap, typed in
    p = '0; p.a_mass = 16'h0100; p.b_mass = 16'h0100;
    w.p = p; w.has_res = 1'b1; w.r = '0;
    rows.push_back(w);
    // coinciding centres with radii, equal and zero masses
    p.a_radius = 13'd1000; p.b_radius = 13'd1000;
    rows.push_back(mk(p, 1'b0));
    p.a_mass = '0; p.b_mass = '0; p.a_vel_x = 16'sh1000; p.b_vel_x = -16'sh1000;
    rows.push_back(mk(p, 1'b0));
    p.a_mass = '0; p.b_mass = 16'hffff;
    rows.push_back(mk(p, 1'b0));
    // large and maximum radii, overlapping, velocity extremes
    p.a_radius = 13'd4096; p.b_radius = 13'h1fff; p.a_mass = 16'hffff; p.b_mass = 16'h0001;
    p.a_pos_x = 16'sh7fff; p.b_pos_x = 16'sh7000; p.a_pos_y = 16'sh8000; p.b_pos_y = 16'sh8100;
    p.a_vel_x = 16'sh8000; p.a_vel_y = 16'sh7fff; p.b_vel_x = 16'sh7fff; p.b_vel_y = 16'sh8000;
    rows.push_back(mk(p, 1'b0));
    p.a_pos_x = 16'sh8000; p.b_pos_x = 16'sh8400; p.a_pos_y = 16'sh7fff; p.b_pos_y = 16'sh7fff;
    rows.push_back(mk(p, 1'b0));
    // exactly touching: distance equals radius sum, no hit; then one unit closer, a hit
    p = '0; p.a_radius = 13'd2048; p.b_radius = 13'd2048; p.b_pos_x = 16'sh1000;
    p.a_mass = 16'h0200; p.b_mass = 16'h0100;
    rows.push_back(mk(p, 1'b0));
    p.b_pos_x = 16'sh0fff;
    rows.push_back(mk(p, 1'b0));
    for (int i = 0; i < 12; i++) rows.push_back(mk(rand_pair(), 1'b0));
  endtask

  // Sender: table then random pairs, with idle bursts
  initial begin
    pair_t p;
    pair_if.valid = 1'b0;
    pair_if.data = '0;
    build_table();
    @(posedge rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < rows.size() + NumRandom; i++) begin
      p = (i < rows.size()) ? rows[i].p : rand_pair();
      if (!quiet && $urandom_range(0, 3) == 0) begin
        pair_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      pair_if.valid <= 1'b1;
      pair_if.data <= p;
      if (i < rows.size() && rows[i].has_res) begin
        if (collide(p) !== rows[i].r) report("typed row", i, 0);
        expected_q.push_back(rows[i].r);
      end else begin
        expected_q.push_back(collide(p));
      end
      @(posedge clk_i);
      while (!pair_if.ready) @(posedge clk_i);
      if (i == 300) long_hold = 1'b1;
      if (i == rows.size() + NumRandom - 300) quiet = 1'b1;
    end
    pair_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls plus one long hold-off
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        res_if.ready <= 1'b0;
        repeat (Latency + 100) @(posedge clk_i);
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Result checker and watchdog
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = expected_q.pop_front();
          if (got.hit !== want.hit) report("hit", got.hit, want.hit);
          if (got.new_a_pos_x !== want.new_a_pos_x)
            report("new_a_pos_x", got.new_a_pos_x, want.new_a_pos_x);
          if (got.new_a_pos_y !== want.new_a_pos_y)
            report("new_a_pos_y", got.new_a_pos_y, want.new_a_pos_y);
          if (got.new_a_vel_x !== want.new_a_vel_x)
            report("new_a_vel_x", got.new_a_vel_x, want.new_a_vel_x);
          if (got.new_a_vel_y !== want.new_a_vel_y)
            report("new_a_vel_y", got.new_a_vel_y, want.new_a_vel_y);
          if (got.new_b_pos_x !== want.new_b_pos_x)
            report("new_b_pos_x", got.new_b_pos_x, want.new_b_pos_x);
          if (got.new_b_pos_y !== want.new_b_pos_y)
            report("new_b_pos_y", got.new_b_pos_y, want.new_b_pos_y);
          if (got.new_b_vel_x !== want.new_b_vel_x)
            report("new_b_vel_x", got.new_b_vel_x, want.new_b_vel_x);
          if (got.new_b_vel_y !== want.new_b_vel_y)
            report("new_b_vel_y", got.new_b_vel_y, want.new_b_vel_y);
        end
      end
      if ((res_if.valid && res_if.ready) || (pair_if.valid && pair_if.ready)) watch <= 0;
      else watch <= watch + 1;
    end
  end

  // Reset, end of run and timeout
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      begin
        wait (stim_done && expected_q.size() == 0);
        repeat (Latency) @(posedge clk_i);
        if (errors == 0 && expected_q.size() == 0) begin
          $display("circle_pair_elastic_collision test passed");
        end else begin
          $display("circle_pair_elastic_collision test failed");
        end
        $finish;
      end
      begin
        wait (watch >= WatchLimit);
        $display("timeout");
        $display("circle_pair_elastic_collision test failed");
        $finish;
      end
    join
  end

endmodule

>>> filelist.f
src/cpec_pkg.sv
src/cpec_if.sv
src/cpec_engine.sv
src/circle_pair_elastic_collision.sv
verif/testbench.sv
